// File: rtl/core/krst_pkg.sv
package krst_pkg;

    localparam int SLOTS       = 16;
    localparam int BLOCK_BYTES = 4096;

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 16;
    localparam int SIZE_W = $clog2(BLOCK_BYTES + 1);
    localparam int OFF_W  = 24;
    localparam int REQ_W  = 32;
    localparam int SID_W  = 8;
    localparam int SEGSZ_W = 17;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] FN_CREATE = 2'd0;
    localparam logic [1:0] FN_ATTACH = 2'd1;
    localparam logic [1:0] FN_DETACH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADSLOT = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  cnt;
        logic [SIZE_W-1:0] size;
    } slot_word_t;

    localparam int WORD_W = $bits(slot_word_t);

    function automatic logic [OFF_W-1:0] offset_of(input logic [IDX_W-1:0] s);
        logic [31:0] p;
        p = 32'(s) * 32'(BLOCK_BYTES);
        return p[OFF_W-1:0];
    endfunction

endpackage

// File: rtl/core/krst_ram.sv
module krst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/keyed_refcount_segment_table_top.sv
// A create scans the slots from slot 0 up to the hit, the free slot or the end (at
// most SLOTS); attach and detach read the one named slot; a rejected operation reads
// nothing. Each then raises m_valid, waiting while an earlier result beat is not taken.
// A new input beat is taken only once the previous item has become a result beat;
// the slot scan reads one table entry a cycle.
// Reset empties the table at once through per-slot written flags; no clearing pass.
module keyed_refcount_segment_table_top
    import krst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [KEY_W-1:0]   s_seg_key,
    input  logic [REQ_W-1:0]   s_request_size,
    input  logic [SID_W-1:0]   s_slot_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [SID_W-1:0]   m_slot_index,
    output logic [OFF_W-1:0]   m_byte_offset,
    output logic [SEGSZ_W-1:0] m_seg_size,
    output logic [CNT_W-1:0]   m_ref_count
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LOOK, S_ERR} state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [1:0]         func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SID_W-1:0]   sid_reg;
    logic [SLOTS-1:0]   vld_reg;
    logic               vld_q_reg;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [SID_W-1:0]   m_slot_reg, m_slot_next;
    logic [OFF_W-1:0]   m_off_reg, m_off_next;
    logic [SEGSZ_W-1:0] m_size_reg, m_size_next;
    logic [CNT_W-1:0]   m_cnt_reg, m_cnt_next;

    logic               rd_en, wr_en, ld, out_free, accept, sid_ok;
    logic [IDX_W-1:0]   rd_addr;
    slot_word_t         wr_word, q_word, entry;
    logic [WORD_W-1:0]  ram_q;
    logic               live, hit, last;
    logic [SIZE_W-1:0]  clamp_size;
    logic [CNT_W-1:0]   dec_cnt;

    krst_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(idx_reg),
        .wdata(wr_word),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(ram_q)
    );

    // A slot never written reads as the reset value: all zero, free.
    assign q_word = slot_word_t'(ram_q);
    assign entry  = vld_q_reg ? q_word : '0;
    assign live   = (entry.cnt != '0);
    assign hit    = live && (entry.key == key_reg);
    assign last   = (idx_reg == IDX_W'(SLOTS - 1));
    assign dec_cnt = entry.cnt - CNT_W'(1);

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign sid_ok     = ({1'b0, s_slot_id} < 9'(SLOTS));
    assign clamp_size = (s_request_size > REQ_W'(BLOCK_BYTES)) ? SIZE_W'(BLOCK_BYTES)
                                                               : s_request_size[SIZE_W-1:0];

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg + IDX_W'(1);
        wr_en         = 1'b0;
        wr_word       = entry;
        ld            = 1'b0;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_off_next    = m_off_reg;
        m_size_next   = m_size_reg;
        m_cnt_next    = m_cnt_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        FN_CREATE: begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                        FN_ATTACH, FN_DETACH: begin
                            if (sid_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = s_slot_id[IDX_W-1:0];
                                idx_next   = s_slot_id[IDX_W-1:0];
                                state_next = S_LOOK;
                            end else begin
                                state_next = S_ERR;
                            end
                        end
                        default: state_next = S_ERR;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit || !live || last) begin
                    if (out_free) begin
                        ld          = 1'b1;
                        state_next  = S_IDLE;
                        m_slot_next = SID_W'(idx_reg);
                        m_off_next  = offset_of(idx_reg);
                        if (hit && entry.cnt == COUNT_MAX) begin
                            m_status_next = ST_SAT;
                            m_size_next   = SEGSZ_W'(entry.size);
                            m_cnt_next    = entry.cnt;
                        end else if (hit) begin
                            wr_en         = 1'b1;
                            wr_word.cnt   = entry.cnt + CNT_W'(1);
                            m_status_next = ST_OK;
                            m_size_next   = SEGSZ_W'(entry.size);
                            m_cnt_next    = entry.cnt + CNT_W'(1);
                        end else if (!live) begin
                            wr_en         = 1'b1;
                            wr_word.key   = key_reg;
                            wr_word.cnt   = CNT_W'(1);
                            wr_word.size  = size_reg;
                            m_status_next = ST_OK;
                            m_size_next   = SEGSZ_W'(size_reg);
                            m_cnt_next    = CNT_W'(1);
                        end else begin
                            m_status_next = ST_FULL;
                            m_slot_next   = '0;
                            m_off_next    = '0;
                            m_size_next   = '0;
                            m_cnt_next    = '0;
                        end
                    end
                end else begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    ld          = 1'b1;
                    state_next  = S_IDLE;
                    m_slot_next = sid_reg;
                    if (!live) begin
                        m_status_next = ST_BADSLOT;
                        m_off_next    = '0;
                        m_size_next   = '0;
                        m_cnt_next    = '0;
                    end else if (func_reg == FN_ATTACH) begin
                        m_status_next = ST_OK;
                        m_off_next    = offset_of(idx_reg);
                        m_size_next   = SEGSZ_W'(entry.size);
                        m_cnt_next    = entry.cnt;
                    end else begin
                        wr_en         = 1'b1;
                        wr_word.cnt   = dec_cnt;
                        wr_word.key   = (dec_cnt == '0) ? '0 : entry.key;
                        m_status_next = ST_OK;
                        m_off_next    = '0;
                        m_size_next   = SEGSZ_W'(entry.size);
                        m_cnt_next    = dec_cnt;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    ld            = 1'b1;
                    state_next    = S_IDLE;
                    m_status_next = ST_BADSLOT;
                    m_slot_next   = (func_reg == FN_ATTACH || func_reg == FN_DETACH)
                                    ? sid_reg : '0;
                    m_off_next    = '0;
                    m_size_next   = '0;
                    m_cnt_next    = '0;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            vld_q_reg   <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            if (wr_en) begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (rd_en) begin
                vld_q_reg <= vld_reg[rd_addr];
            end
        end
        if (accept) begin
            func_reg <= s_func;
            key_reg  <= s_seg_key;
            size_reg <= clamp_size;
            sid_reg  <= s_slot_id;
        end
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_off_reg    <= m_off_next;
        m_size_reg   <= m_size_next;
        m_cnt_reg    <= m_cnt_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot_index  = m_slot_reg;
    assign m_byte_offset = m_off_reg;
    assign m_seg_size    = m_size_reg;
    assign m_ref_count   = m_cnt_reg;

    // The table is only written while a looked-up entry is being resolved.
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_SCAN || state_reg == S_LOOK))
        else $error("table write outside of a lookup");

    // A resolved item always shows up as a result beat in the next cycle.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ld |=> (m_valid && state_reg == S_IDLE))
        else $error("result beat missing after resolve");

    // A full table reports nothing but the status.
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |->
        (m_slot_index == '0 && m_ref_count == '0 && m_byte_offset == '0))
        else $error("full status with nonzero fields");

    // A successful create never reports a free slot.
    a_ok_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld && m_status_next == ST_OK && state_reg == S_SCAN) |-> (m_cnt_next != '0))
        else $error("create reported zero count");

endmodule
